// ===== design/rcdf_pkg.sv =====
// rcdf_pkg: shared types, command codes and constants for the canvas block
// no dependencies
package rcdf_pkg;

   localparam int DefMaxWidth  = 256;
   localparam int DefMaxHeight = 256;
   localparam logic [7:0] Blank = 8'd79;

   typedef enum logic [2:0] {
      KIND_CLEAR = 3'd0,
      KIND_PIXEL = 3'd1,
      KIND_VERT  = 3'd2,
      KIND_HORZ  = 3'd3,
      KIND_RECT  = 3'd4,
      KIND_FLOOD = 3'd5,
      KIND_READ  = 3'd6,
      KIND_NONE  = 3'd7
   } kind_type;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_NOP   = 3'd0,
      OP_BOX   = 3'd1,
      OP_FLOOD = 3'd2,
      OP_READ  = 3'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       bad;
      logic [9:0] r0;
      logic [9:0] r1;
      logic [9:0] c0;
      logic [9:0] c1;
      logic [7:0] colour;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLR,
      ST_BOX,
      ST_RD_ISSUE,
      ST_RD_WAIT,
      ST_FL_SEED,
      ST_FL_SEEDCHK,
      ST_FL_POP,
      ST_FL_POPWAIT,
      ST_FL_NB_ISSUE,
      ST_FL_NB_CHECK,
      ST_DONE
   } state_type;

   localparam int CsrWidth  = 0;
   localparam int CsrHeight = 1;

endpackage

// ===== design/raster_canvas_draw_fill.sv =====
// throughput: one command at a time through the single canvas memory port
// front queue of two commands accepts while the back end works
// reset: synchronous; after reset a clearing pass writes 'O' to every canvas
// cell, one per cycle, before commands run
// depends on rcdf_pkg, rcdf_front, rcdf_back
module raster_canvas_draw_fill #(
   parameter int MAX_WIDTH  = rcdf_pkg::DefMaxWidth,
   parameter int MAX_HEIGHT = rcdf_pkg::DefMaxHeight
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_col_a,
   input  logic [7:0] req_row_a,
   input  logic [7:0] req_col_b,
   input  logic [7:0] req_row_b,
   input  logic [7:0] req_colour,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_colour,
   output logic       rsp_bad_coordinate,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [8:0] csr_wdata
);

   logic [9:0] width_ff, width_in, height_ff, height_in;
   logic       cmd_valid, cmd_ready;
   rcdf_pkg::cmd_type cmd;

   function automatic logic [9:0] clamp(input logic [8:0] v, input int mx);
      logic [10:0] m;
      m = 11'(mx);
      if (v == 9'd0) clamp = 10'd1;
      else if ({2'b00, v} > m) clamp = m[9:0];
      else clamp = {1'b0, v};
   endfunction

   // size registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we && csr_index == 1'(rcdf_pkg::CsrWidth))  width_in  = clamp(csr_wdata, MAX_WIDTH);
      if (csr_we && csr_index == 1'(rcdf_pkg::CsrHeight)) height_in = clamp(csr_wdata, MAX_HEIGHT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp(9'd256, MAX_WIDTH);
         height_ff <= clamp(9'd256, MAX_HEIGHT);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   rcdf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_col_a, .req_row_a,
      .req_col_b, .req_row_b, .req_colour, .width(width_ff), .height(height_ff),
      .cmd_valid, .cmd_ready, .cmd
   );

   rcdf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
      .clock, .reset, .width(width_ff), .height(height_ff), .cmd_valid, .cmd_ready,
      .cmd, .rsp_valid, .rsp_ready, .rsp_read_colour, .rsp_bad_coordinate
   );

   // a bad coordinate never reports a colour
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_coordinate |-> rsp_read_colour == 8'd0)
      else $error("bad coordinate with nonzero colour");

   // back end takes no command while a result waits
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !cmd_ready)
      else $error("command taken over pending result");

   // size registers are never zero
   a_dims: assert property (@(posedge clock) disable iff (reset)
      width_ff != 10'd0 && height_ff != 10'd0)
      else $error("zero canvas size");

endmodule

// ===== design/rcdf_front.sv =====
// rcdf_front: accepts commands, checks coordinates, orders ends, queues them
// depends on rcdf_pkg
module rcdf_front #(
   parameter int MAX_WIDTH  = rcdf_pkg::DefMaxWidth,
   parameter int MAX_HEIGHT = rcdf_pkg::DefMaxHeight
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_kind,
   input  logic [7:0]            req_col_a,
   input  logic [7:0]            req_row_a,
   input  logic [7:0]            req_col_b,
   input  logic [7:0]            req_row_b,
   input  logic [7:0]            req_colour,
   input  logic [9:0]            width,
   input  logic [9:0]            height,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output rcdf_pkg::cmd_type     cmd
);

   localparam int Depth = 2;

   rcdf_pkg::cmd_type q_ff [Depth];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   rcdf_pkg::cmd_type cls;
   logic [9:0] ca, ra, cb, rb;
   logic a_ok, cb_ok, rb_ok;
   logic push, pop;

   assign ca = {2'b00, req_col_a};
   assign ra = {2'b00, req_row_a};
   assign cb = {2'b00, req_col_b};
   assign rb = {2'b00, req_row_b};
   assign a_ok  = (ca < width) && (ra < height);
   assign cb_ok = cb < width;
   assign rb_ok = rb < height;

   // classify and order segment ends
   always_comb begin
      cls.op     = rcdf_pkg::OP_NOP;
      cls.bad    = 1'b0;
      cls.r0     = (ra < rb) ? ra : rb;
      cls.r1     = (ra < rb) ? rb : ra;
      cls.c0     = (ca < cb) ? ca : cb;
      cls.c1     = (ca < cb) ? cb : ca;
      cls.colour = req_colour;
      unique case (rcdf_pkg::kind_type'(req_kind))
         rcdf_pkg::KIND_CLEAR: begin
            cls.op = rcdf_pkg::OP_BOX;
            cls.r0 = '0; cls.r1 = height - 10'd1;
            cls.c0 = '0; cls.c1 = width - 10'd1;
            cls.colour = rcdf_pkg::Blank;
         end
         rcdf_pkg::KIND_PIXEL: begin
            cls.bad = !a_ok;
            cls.op = rcdf_pkg::OP_BOX;
            cls.r0 = ra; cls.r1 = ra; cls.c0 = ca; cls.c1 = ca;
         end
         rcdf_pkg::KIND_VERT: begin
            cls.bad = !(a_ok && rb_ok);
            cls.op = rcdf_pkg::OP_BOX;
            cls.c0 = ca; cls.c1 = ca;
         end
         rcdf_pkg::KIND_HORZ: begin
            cls.bad = !(a_ok && cb_ok);
            cls.op = rcdf_pkg::OP_BOX;
            cls.r0 = ra; cls.r1 = ra;
         end
         rcdf_pkg::KIND_RECT: begin
            cls.bad = !(a_ok && cb_ok && rb_ok);
            cls.op = rcdf_pkg::OP_BOX;
         end
         rcdf_pkg::KIND_FLOOD: begin
            cls.bad = !a_ok;
            cls.op = rcdf_pkg::OP_FLOOD;
            cls.r0 = ra; cls.c0 = ca;
         end
         rcdf_pkg::KIND_READ: begin
            cls.bad = !a_ok;
            cls.op = rcdf_pkg::OP_READ;
            cls.r0 = ra; cls.c0 = ca;
         end
         default: cls.op = rcdf_pkg::OP_NOP;
      endcase
      if (cls.bad) cls.op = rcdf_pkg::OP_NOP;
   end

   assign req_ready = cnt_ff != 2'(Depth);
   assign push = req_valid && req_ready;
   assign cmd_valid = cnt_ff != 2'd0;
   assign pop = cmd_valid && cmd_ready;
   assign cmd = q_ff[rp_ff];

   // queue pointers
   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= cls;
   end

endmodule

// ===== design/rcdf_back.sv =====
// rcdf_back: canvas memory, fill stack and the drawing / flood sequencer
// depends on rcdf_pkg
module rcdf_back #(
   parameter int MAX_WIDTH  = rcdf_pkg::DefMaxWidth,
   parameter int MAX_HEIGHT = rcdf_pkg::DefMaxHeight
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [9:0]        width,
   input  logic [9:0]        height,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  rcdf_pkg::cmd_type cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_read_colour,
   output logic              rsp_bad_coordinate
);

   localparam int CW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int AW    = CW + RW;
   localparam int Cells = 1 << AW;
   localparam int SW    = $clog2(Cells + 1);

   logic [7:0]    mem [Cells];
   logic [AW-1:0] stk [Cells];

   rcdf_pkg::state_type st_ff, st_in;
   rcdf_pkg::cmd_type   c_ff;
   logic [9:0]    r_ff, r_in, cc_ff, cc_in;
   logic [9:0]    pr_ff, pr_in, pc_ff, pc_in;
   logic [1:0]    nb_ff, nb_in;
   logic [7:0]    old_ff, old_in;
   logic [SW-1:0] sp_ff, sp_in;
   logic [AW:0]   clr_ff, clr_in;
   logic [7:0]    rd_ff;
   logic [AW-1:0] stk_q;
   logic [7:0]    out_col_ff, out_col_in;
   logic          out_bad_ff, out_bad_in;
   logic          ov_ff, ov_in;
   logic          take;

   // memory port control
   logic          mwe, mre, swe, sre;
   logic [AW-1:0] maddr, saddr;
   logic [7:0]    mwd;
   logic [AW-1:0] swd;
   logic [9:0]    nr, nc;
   logic          nb_ok;

   function automatic logic [AW-1:0] addr_of(input logic [9:0] r, input logic [9:0] c);
      addr_of = {r[RW-1:0], c[CW-1:0]};
   endfunction

   assign take = cmd_valid && cmd_ready;
   assign cmd_ready = (st_ff == rcdf_pkg::ST_IDLE) && !ov_ff && (clr_ff[AW] == 1'b1);

   // neighbor select: up, down, left, right
   always_comb begin
      nr = pr_ff; nc = pc_ff; nb_ok = 1'b0;
      case (nb_ff)
         2'd0: begin nr = pr_ff - 10'd1; nb_ok = pr_ff != 10'd0; end
         2'd1: begin nr = pr_ff + 10'd1; nb_ok = (pr_ff + 10'd1) < height; end
         2'd2: begin nc = pc_ff - 10'd1; nb_ok = pc_ff != 10'd0; end
         default: begin nc = pc_ff + 10'd1; nb_ok = (pc_ff + 10'd1) < width; end
      endcase
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         rcdf_pkg::ST_IDLE:
            if (take) begin
               unique case (cmd.op)
                  rcdf_pkg::OP_BOX:   st_in = rcdf_pkg::ST_BOX;
                  rcdf_pkg::OP_FLOOD: st_in = rcdf_pkg::ST_FL_SEED;
                  rcdf_pkg::OP_READ:  st_in = rcdf_pkg::ST_RD_ISSUE;
                  default:            st_in = rcdf_pkg::ST_DONE;
               endcase
            end
         rcdf_pkg::ST_CLR:      st_in = rcdf_pkg::ST_IDLE;
         rcdf_pkg::ST_BOX:
            if (r_ff == c_ff.r1 && cc_ff == c_ff.c1) st_in = rcdf_pkg::ST_DONE;
         rcdf_pkg::ST_RD_ISSUE: st_in = rcdf_pkg::ST_RD_WAIT;
         rcdf_pkg::ST_RD_WAIT:  st_in = rcdf_pkg::ST_DONE;
         rcdf_pkg::ST_FL_SEED:  st_in = rcdf_pkg::ST_FL_SEEDCHK;
         rcdf_pkg::ST_FL_SEEDCHK:
            st_in = (rd_ff == c_ff.colour) ? rcdf_pkg::ST_DONE : rcdf_pkg::ST_FL_POP;
         rcdf_pkg::ST_FL_POP:
            st_in = (sp_ff == '0) ? rcdf_pkg::ST_DONE : rcdf_pkg::ST_FL_POPWAIT;
         rcdf_pkg::ST_FL_POPWAIT: st_in = rcdf_pkg::ST_FL_NB_ISSUE;
         rcdf_pkg::ST_FL_NB_ISSUE:
            if (nb_ok) st_in = rcdf_pkg::ST_FL_NB_CHECK;
            else if (nb_ff == 2'd3) st_in = rcdf_pkg::ST_FL_POP;
         rcdf_pkg::ST_FL_NB_CHECK:
            st_in = (nb_ff == 2'd3) ? rcdf_pkg::ST_FL_POP : rcdf_pkg::ST_FL_NB_ISSUE;
         rcdf_pkg::ST_DONE:     st_in = rcdf_pkg::ST_IDLE;
         default:               st_in = rcdf_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      r_in = r_ff; cc_in = cc_ff; pr_in = pr_ff; pc_in = pc_ff;
      nb_in = nb_ff; old_in = old_ff; sp_in = sp_ff;
      clr_in = clr_ff;
      out_col_in = out_col_ff; out_bad_in = out_bad_ff;
      ov_in = ov_ff && !rsp_ready;
      mwe = 1'b0; mre = 1'b0; swe = 1'b0; sre = 1'b0;
      maddr = addr_of(r_ff, cc_ff); mwd = c_ff.colour;
      saddr = sp_ff[AW-1:0]; swd = addr_of(pr_ff, pc_ff);
      if (clr_ff[AW] == 1'b0) begin
         mwe = 1'b1; maddr = clr_ff[AW-1:0]; mwd = rcdf_pkg::Blank;
         clr_in = clr_ff + (AW+1)'(1);
      end
      unique case (st_ff)
         rcdf_pkg::ST_IDLE:
            if (take) begin
               r_in = cmd.r0; cc_in = cmd.c0; pr_in = cmd.r0; pc_in = cmd.c0;
               sp_in = '0;
            end
         rcdf_pkg::ST_BOX: begin
            mwe = 1'b1;
            if (cc_ff == c_ff.c1) begin
               cc_in = c_ff.c0; r_in = r_ff + 10'd1;
            end else cc_in = cc_ff + 10'd1;
         end
         rcdf_pkg::ST_RD_ISSUE: mre = 1'b1;
         rcdf_pkg::ST_FL_SEED: mre = 1'b1;
         rcdf_pkg::ST_FL_SEEDCHK: begin
            old_in = rd_ff;
            if (rd_ff != c_ff.colour) begin
               mwe = 1'b1;
               swe = 1'b1; saddr = '0; swd = addr_of(r_ff, cc_ff);
               sp_in = SW'(1);
            end
         end
         rcdf_pkg::ST_FL_POP:
            if (sp_ff != '0) begin
               sre = 1'b1; saddr = AW'(sp_ff - SW'(1)); sp_in = sp_ff - SW'(1);
            end
         rcdf_pkg::ST_FL_POPWAIT: begin
            pr_in = {{(10-RW){1'b0}}, stk_q[AW-1:CW]};
            pc_in = {{(10-CW){1'b0}}, stk_q[CW-1:0]};
            nb_in = 2'd0;
         end
         rcdf_pkg::ST_FL_NB_ISSUE:
            if (nb_ok) begin
               mre = 1'b1; maddr = addr_of(nr, nc); r_in = nr; cc_in = nc;
            end else nb_in = nb_ff + 2'd1;
         rcdf_pkg::ST_FL_NB_CHECK: begin
            if (rd_ff == old_ff) begin
               mwe = 1'b1;
               swe = 1'b1; swd = addr_of(r_ff, cc_ff);
               sp_in = sp_ff + SW'(1);
            end
            nb_in = nb_ff + 2'd1;
         end
         rcdf_pkg::ST_DONE: begin
            ov_in = 1'b1;
            out_bad_in = c_ff.bad;
            out_col_in = (c_ff.op == rcdf_pkg::OP_READ) ? rd_ff : 8'd0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= rcdf_pkg::ST_IDLE;
         ov_ff  <= 1'b0;
         sp_ff  <= '0;
         clr_ff <= '0;
      end else begin
         st_ff  <= st_in;
         ov_ff  <= ov_in;
         sp_ff  <= sp_in;
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) c_ff <= cmd;
      r_ff <= r_in; cc_ff <= cc_in; pr_ff <= pr_in; pc_ff <= pc_in;
      nb_ff <= nb_in; old_ff <= old_in;
      out_col_ff <= out_col_in; out_bad_ff <= out_bad_in;
   end

   // canvas memory, one port
   always_ff @(posedge clock) begin
      if (mwe) mem[maddr] <= mwd;
      if (mre) rd_ff <= mem[maddr];
   end

   // fill stack memory
   always_ff @(posedge clock) begin
      if (swe) stk[saddr] <= swd;
      if (sre) stk_q <= stk[saddr];
   end

   assign rsp_valid = ov_ff;
   assign rsp_read_colour = out_col_ff;
   assign rsp_bad_coordinate = out_bad_ff;

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for the raster canvas block with drawing and flood fill
// depends on rcdf_pkg and raster_canvas_draw_fill
module testbench;

   typedef struct {
      rcdf_pkg::kind_type kind;
      logic [7:0] col_a;
      logic [7:0] row_a;
      logic [7:0] col_b;
      logic [7:0] row_b;
      logic [7:0] colour;
   } draw_cmd_type;

   typedef struct {
      logic [7:0] read_colour;
      logic       bad_coordinate;
   } draw_rsp_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [2:0] req_kind;
   logic [7:0] req_col_a, req_row_a, req_col_b, req_row_b, req_colour;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_read_colour;
   logic       rsp_bad_coordinate;
   logic       csr_we;
   logic       csr_index;
   logic [8:0] csr_wdata;

   draw_cmd_type pending_cmds[$];
   draw_rsp_type expected_rsps[$];
   int         accepted_count;
   int         answered_count;
   int         error_count;
   bit         calm;

   // predictor state
   logic [7:0] shadow_canvas[65536];
   int         shadow_width;
   int         shadow_height;
   int         fill_stack[$];

   raster_canvas_draw_fill uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_col_a(req_col_a), .req_row_a(req_row_a),
      .req_col_b(req_col_b), .req_row_b(req_row_b), .req_colour(req_colour),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_read_colour(rsp_read_colour), .rsp_bad_coordinate(rsp_bad_coordinate),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(12 * 20000000);
      $display("CHECK FAILED");
      $finish;
   end

   // predictor helpers
   function automatic int clamp_size(input logic [8:0] v);
      if (v == 9'd0) return 1;
      if (v > 9'd256) return 256;
      return int'(v);
   endfunction

   function automatic void paint_span(input int r0, input int r1, input int c0, input int c1,
                                      input logic [7:0] colour);
      int t;
      if (r0 > r1) begin
         t = r0; r0 = r1; r1 = t;
      end
      if (c0 > c1) begin
         t = c0; c0 = c1; c1 = t;
      end
      for (int r = r0; r <= r1; r++)
         for (int c = c0; c <= c1; c++)
            shadow_canvas[r * 256 + c] = colour;
   endfunction

   function automatic void mark_pixel(input int r, input int c, input logic [7:0] old,
                                      input logic [7:0] colour);
      if (shadow_canvas[r * 256 + c] == old) begin
         shadow_canvas[r * 256 + c] = colour;
         fill_stack.push_back(r * 256 + c);
      end
   endfunction

   function automatic void flood_region(input int r, input int c, input logic [7:0] colour);
      logic [7:0] old;
      int         idx, pr, pc;
      old = shadow_canvas[r * 256 + c];
      if (old == colour) return;
      fill_stack.delete();
      mark_pixel(r, c, old, colour);
      while (fill_stack.size() > 0) begin
         idx = fill_stack.pop_back();
         pr = idx / 256;
         pc = idx % 256;
         if (pr > 0) mark_pixel(pr - 1, pc, old, colour);
         if (pr + 1 < shadow_height) mark_pixel(pr + 1, pc, old, colour);
         if (pc > 0) mark_pixel(pr, pc - 1, old, colour);
         if (pc + 1 < shadow_width) mark_pixel(pr, pc + 1, old, colour);
      end
   endfunction

   // apply one command to the shadow canvas and return its response
   function automatic draw_rsp_type draw_canvas(input draw_cmd_type c);
      draw_rsp_type rsp;
      bit        a_ok;
      int        ca, ra, cb, rb;
      ca = c.col_a; ra = c.row_a; cb = c.col_b; rb = c.row_b;
      rsp.read_colour = 8'd0;
      rsp.bad_coordinate = 1'b0;
      a_ok = ca < shadow_width && ra < shadow_height;
      case (c.kind)
         rcdf_pkg::KIND_CLEAR:
            paint_span(0, shadow_height - 1, 0, shadow_width - 1, rcdf_pkg::Blank);
         rcdf_pkg::KIND_PIXEL: begin
            if (!a_ok) rsp.bad_coordinate = 1'b1;
            else shadow_canvas[ra * 256 + ca] = c.colour;
         end
         rcdf_pkg::KIND_VERT: begin
            if (!a_ok || rb >= shadow_height) rsp.bad_coordinate = 1'b1;
            else paint_span(ra, rb, ca, ca, c.colour);
         end
         rcdf_pkg::KIND_HORZ: begin
            if (!a_ok || cb >= shadow_width) rsp.bad_coordinate = 1'b1;
            else paint_span(ra, ra, ca, cb, c.colour);
         end
         rcdf_pkg::KIND_RECT: begin
            if (!a_ok || cb >= shadow_width || rb >= shadow_height) rsp.bad_coordinate = 1'b1;
            else paint_span(ra, rb, ca, cb, c.colour);
         end
         rcdf_pkg::KIND_FLOOD: begin
            if (!a_ok) rsp.bad_coordinate = 1'b1;
            else flood_region(ra, ca, c.colour);
         end
         rcdf_pkg::KIND_READ: begin
            if (!a_ok) rsp.bad_coordinate = 1'b1;
            else rsp.read_colour = shadow_canvas[ra * 256 + ca];
         end
         default: ;
      endcase
      return rsp;
   endfunction

   // request driver with random idle bursts
   int send_gap;
   always @(posedge clock) begin
      draw_cmd_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 12);
            req_valid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            nxt = pending_cmds.pop_front();
            req_valid  <= 1'b1;
            req_kind   <= nxt.kind;
            req_col_a  <= nxt.col_a;
            req_row_a  <= nxt.row_a;
            req_col_b  <= nxt.col_b;
            req_row_b  <= nxt.row_b;
            req_colour <= nxt.colour;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall pattern
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: predict on each accepted request beat, check each response beat
   always @(posedge clock) begin
      draw_cmd_type c;
      draw_rsp_type want;
      if (!reset && req_valid && req_ready) begin
         c.kind = rcdf_pkg::kind_type'(req_kind);
         c.col_a = req_col_a; c.row_a = req_row_a;
         c.col_b = req_col_b; c.row_b = req_row_b;
         c.colour = req_colour;
         expected_rsps.push_back(draw_canvas(c));
         accepted_count++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         answered_count++;
         if (expected_rsps.size() == 0) begin
            $error("response beat with nothing expected");
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_read_colour !== want.read_colour) begin
               $error("read_colour expected %0d actual %0d", want.read_colour,
                      rsp_read_colour);
               error_count++;
            end
            if (rsp_bad_coordinate !== want.bad_coordinate) begin
               $error("bad_coordinate expected %0d actual %0d", want.bad_coordinate,
                      rsp_bad_coordinate);
               error_count++;
            end
         end
      end
   end

   // stimulus helpers
   task automatic add_cmd(input rcdf_pkg::kind_type k, input int ca, input int ra,
                          input int cb, input int rb, input int colour);
      draw_cmd_type c;
      c.kind = k;
      c.col_a = ca[7:0]; c.row_a = ra[7:0];
      c.col_b = cb[7:0]; c.row_b = rb[7:0];
      c.colour = colour[7:0];
      pending_cmds.push_back(c);
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || req_valid || answered_count != accepted_count
             || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_size(input logic idx, input logic [8:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == 1'(rcdf_pkg::CsrWidth)) shadow_width = clamp_size(v);
      else shadow_height = clamp_size(v);
   endtask

   function automatic int pick_coord(input int dim);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
      return $urandom_range(0, dim - 1);
   endfunction

   function automatic int pick_colour();
      case ($urandom_range(0, 3))
         0: return rcdf_pkg::Blank;
         1: return $urandom_range(0, 255);
         default: return $urandom_range(0, 3);
      endcase
   endfunction

   // random commands on a small canvas: mostly in-window drawing and fills
   task automatic add_small_random(input int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 39);
         if (k == 0) add_cmd(rcdf_pkg::KIND_CLEAR, $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255), pick_colour());
         else if (k == 1) add_cmd(rcdf_pkg::KIND_NONE, $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 255));
         else add_cmd(rcdf_pkg::kind_type'($urandom_range(1, 6)), pick_coord(shadow_width),
                      pick_coord(shadow_height), pick_coord(shadow_width),
                      pick_coord(shadow_height), pick_colour());
      end
   endtask

   // random commands on the full canvas: short spans only, no fills or clears
   function automatic int near(input int a);
      int b;
      b = a + $urandom_range(0, 14) - 7;
      if (b < 0) b = 0;
      if (b > 255) b = 255;
      return b;
   endfunction

   task automatic add_full_random(input int n);
      int ca, ra;
      rcdf_pkg::kind_type k;
      for (int i = 0; i < n; i++) begin
         ca = $urandom_range(0, 255);
         ra = $urandom_range(0, 255);
         case ($urandom_range(0, 5))
            0: k = rcdf_pkg::KIND_PIXEL;
            1: k = rcdf_pkg::KIND_VERT;
            2: k = rcdf_pkg::KIND_HORZ;
            3: k = rcdf_pkg::KIND_RECT;
            4: k = rcdf_pkg::KIND_NONE;
            default: k = rcdf_pkg::KIND_READ;
         endcase
         add_cmd(k, ca, ra, near(ca), near(ra), $urandom_range(0, 255));
      end
   endtask

   // main sequence
   initial begin
      req_valid = 1'b0;
      req_kind = rcdf_pkg::KIND_NONE;
      req_col_a = 8'd0; req_row_a = 8'd0; req_col_b = 8'd0; req_row_b = 8'd0;
      req_colour = 8'd0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = 9'd0;
      accepted_count = 0;
      answered_count = 0;
      error_count = 0;
      calm = 1'b0;
      shadow_width = 256;
      shadow_height = 256;
      for (int i = 0; i < 65536; i++) shadow_canvas[i] = rcdf_pkg::Blank;

      // directed: corners, reversed ends, enclosed and isolated fills
      add_cmd(rcdf_pkg::KIND_READ, 0, 0, 0, 0, 0);
      add_cmd(rcdf_pkg::KIND_PIXEL, 255, 255, 0, 0, 255);
      add_cmd(rcdf_pkg::KIND_READ, 255, 255, 255, 255, 0);
      add_cmd(rcdf_pkg::KIND_VERT, 3, 9, 0, 4, 17);
      add_cmd(rcdf_pkg::KIND_HORZ, 254, 2, 248, 0, 18);
      add_cmd(rcdf_pkg::KIND_RECT, 14, 14, 10, 10, 5);
      add_cmd(rcdf_pkg::KIND_RECT, 11, 11, 13, 13, 9);
      add_cmd(rcdf_pkg::KIND_FLOOD, 12, 12, 0, 0, 7);
      add_cmd(rcdf_pkg::KIND_READ, 13, 11, 0, 0, 0);
      add_cmd(rcdf_pkg::KIND_READ, 10, 12, 0, 0, 0);
      add_cmd(rcdf_pkg::KIND_PIXEL, 100, 100, 0, 0, 3);
      add_cmd(rcdf_pkg::KIND_FLOOD, 100, 100, 0, 0, 4);
      add_cmd(rcdf_pkg::KIND_FLOOD, 100, 100, 0, 0, 4);
      add_cmd(rcdf_pkg::KIND_READ, 100, 100, 0, 0, 0);
      add_cmd(rcdf_pkg::KIND_READ, 101, 100, 0, 0, 0);
      add_cmd(rcdf_pkg::KIND_NONE, 255, 255, 255, 255, 255);
      add_full_random(40);
      add_cmd(rcdf_pkg::KIND_CLEAR, 0, 0, 0, 0, 0);
      add_cmd(rcdf_pkg::KIND_READ, 255, 255, 0, 0, 0);
      wait_drained();

      // 1x1 canvas via zero sizes
      write_size(1'(rcdf_pkg::CsrWidth), 9'd0);
      write_size(1'(rcdf_pkg::CsrHeight), 9'd0);
      add_cmd(rcdf_pkg::KIND_FLOOD, 0, 0, 0, 0, 0);
      add_cmd(rcdf_pkg::KIND_READ, 1, 0, 0, 0, 0);
      add_cmd(rcdf_pkg::KIND_RECT, 0, 0, 0, 1, 6);
      add_cmd(rcdf_pkg::KIND_CLEAR, 0, 0, 0, 0, 0);
      add_small_random(30);
      wait_drained();

      write_size(1'(rcdf_pkg::CsrWidth), 9'd8);
      write_size(1'(rcdf_pkg::CsrHeight), 9'd8);
      add_small_random(110);
      wait_drained();

      write_size(1'(rcdf_pkg::CsrWidth), 9'd511);
      write_size(1'(rcdf_pkg::CsrHeight), 9'd4);
      add_small_random(80);
      wait_drained();

      write_size(1'(rcdf_pkg::CsrWidth), 9'd4);
      write_size(1'(rcdf_pkg::CsrHeight), 9'd300);
      add_small_random(80);
      wait_drained();

      write_size(1'(rcdf_pkg::CsrWidth), 9'd16);
      write_size(1'(rcdf_pkg::CsrHeight), 9'd5);
      add_small_random(100);
      wait_drained();

      // last part without idling
      calm = 1'b1;
      write_size(1'(rcdf_pkg::CsrWidth), 9'd12);
      write_size(1'(rcdf_pkg::CsrHeight), 9'd10);
      add_small_random(100);
      wait_drained();
      repeat (50) @(posedge clock);

      if (error_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
design/rcdf_pkg.sv
design/rcdf_front.sv
design/rcdf_back.sv
design/raster_canvas_draw_fill.sv
test/testbench.sv
